[hdl/iole_pkg.sv]
`default_nettype none
package iole_pkg;
  // Index width able to hold the largest supported capacity (4096)
  localparam int IDX_W = 13;
  localparam int DEF_CAPACITY = 64;
  localparam int DATA_W = 32;
  localparam int OP_W = 4;
  localparam int POS_W = 8;
  localparam int ST_W = 2;
  localparam int CNT_W = 7;

  localparam logic [OP_W-1:0] OP_FRONT   = 4'd0;
  localparam logic [OP_W-1:0] OP_APPEND  = 4'd1;
  localparam logic [OP_W-1:0] OP_INS_AT  = 4'd2;
  localparam logic [OP_W-1:0] OP_POP_LST = 4'd3;
  localparam logic [OP_W-1:0] OP_POP_FST = 4'd4;
  localparam logic [OP_W-1:0] OP_REM_AT  = 4'd5;
  localparam logic [OP_W-1:0] OP_READ    = 4'd6;
  localparam logic [OP_W-1:0] OP_SEARCH  = 4'd7;
  localparam logic [OP_W-1:0] OP_SORTED  = 4'd8;
  localparam logic [OP_W-1:0] OP_REVERSE = 4'd9;
  localparam logic [OP_W-1:0] OP_LENGTH  = 4'd10;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd2;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd3;

  localparam logic [1:0] MD_HOLD = 2'd0;
  localparam logic [1:0] MD_INS  = 2'd1;
  localparam logic [1:0] MD_REM  = 2'd2;

  // Broadcast to every cell
  typedef struct packed {
    logic [1:0]        mode;
    logic [IDX_W-1:0]  idx;   // insert slot / remove slot
    logic [IDX_W-1:0]  hi;    // shift bound: last shifting slot on insert, one past it on remove
    logic [IDX_W-1:0]  rd;    // slot driven onto the read bus
    logic [IDX_W-1:0]  n;     // current length
    logic [DATA_W-1:0] data;  // value written into slot idx
    logic [DATA_W-1:0] key;   // search key
  } cell_ctrl_t;

  typedef struct packed {
    logic [DATA_W-1:0] rd_val; // own value if selected, else zero
    logic              hit;    // holds key, inside list
    logic              bad;    // greater than right neighbor, inside list
  } cell_stat_t;
endpackage
`default_nettype wire

[hdl/iole_cell.sv]
`default_nettype none
module iole_cell
  import iole_pkg::*;
#(
  parameter int IDX = 0
) (
  input  wire logic              clk,
  input  cell_ctrl_t             ctrl,
  input  wire logic [DATA_W-1:0] left_val,
  input  wire logic [DATA_W-1:0] right_val,
  output logic      [DATA_W-1:0] val,
  output cell_stat_t             stat
);
  localparam logic [IDX_W-1:0] K = IDX_W'(IDX);

  always_ff @(posedge clk) begin
    unique case (ctrl.mode)
      MD_INS: begin
        if (K == ctrl.idx) begin
          val <= ctrl.data;
        end else if (K > ctrl.idx && K <= ctrl.hi) begin
          val <= left_val;
        end
      end
      MD_REM: begin
        if (K >= ctrl.idx && K < ctrl.hi) begin
          val <= right_val;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    stat.rd_val = (K == ctrl.rd) ? val : '0;
    stat.hit    = (K < ctrl.n) && (val == ctrl.key);
    stat.bad    = ((K + 1'b1) < ctrl.n) && ($signed(val) > $signed(right_val));
  end
endmodule
`default_nettype wire

[hdl/indexed_ordered_list_engine.sv]
`default_nettype none
// Ordered list engine for up to CAPACITY signed 32-bit values, one command per item
// (insert front/end/position, pop last/first, remove at position, read, search,
// sorted test, reverse, length) and exactly one result item per command. Values sit
// in a row of cells, one per slot; inserts and removals shift every affected cell
// toward its neighbor at once, so all commands except reverse go from acceptance
// straight to a registered result. Reverse of n >= 2 elements stalls the input
// while it runs: each step moves the last element into the next slot from the
// front through the shared read bus. Search and sorted test reduce the per-cell
// compare outputs across the row. The output register lets a new item be taken
// while the previous result is being consumed. No clearing pass after reset: slots
// beyond the length are never observed.
module indexed_ordered_list_engine
  import iole_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [OP_W-1:0]   opcode,
  input  wire logic [DATA_W-1:0] data_value,
  input  wire logic [POS_W-1:0]  position,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic      [ST_W-1:0]   status,
  output logic      [DATA_W-1:0] result_value,
  output logic                   flag,
  output logic      [CNT_W-1:0]  count
);
  localparam logic [IDX_W-1:0] CAP = IDX_W'(CAPACITY);

  logic [IDX_W-1:0] n, n_next;      // element count
  logic             busy;           // reverse in progress
  logic [IDX_W-1:0] rv_i;           // reverse step slot

  cell_ctrl_t       ctrl;
  logic [DATA_W-1:0] cval [CAPACITY];
  cell_stat_t        cstat [CAPACITY];

  logic [DATA_W-1:0] rd_bus;
  logic              any_hit, any_bad;
  logic              accept;
  logic [IDX_W-1:0]  pos_w;
  logic [ST_W-1:0]   st_c;
  logic [DATA_W-1:0] val_c;
  logic              flag_c;
  logic              rv_start, rv_done;

  assign in_stall = busy | (out_valid & out_stall);
  assign accept   = in_valid & ~in_stall;
  assign pos_w    = IDX_W'(position);

  // Cell row; ends see zero neighbors
  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic [DATA_W-1:0] lv, rv;
    if (k == 0) begin : g_l0
      assign lv = '0;
    end else begin : g_ln
      assign lv = cval[k-1];
    end
    if (k == CAPACITY - 1) begin : g_r0
      assign rv = '0;
    end else begin : g_rn
      assign rv = cval[k+1];
    end
    iole_cell #(.IDX(k)) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .left_val  (lv),
      .right_val (rv),
      .val       (cval[k]),
      .stat      (cstat[k])
    );
  end

  // Row reductions
  always_comb begin
    rd_bus  = '0;
    any_hit = 1'b0;
    any_bad = 1'b0;
    for (int k = 0; k < CAPACITY; k++) begin
      rd_bus  = rd_bus | cstat[k].rd_val;
      any_hit = any_hit | cstat[k].hit;
      any_bad = any_bad | cstat[k].bad;
    end
  end

  // Command decode: cell control and result
  always_comb begin
    ctrl.mode = MD_HOLD;
    ctrl.idx  = '0;
    ctrl.hi   = n;
    ctrl.rd   = pos_w;
    ctrl.n    = n;
    ctrl.data = data_value;
    ctrl.key  = data_value;
    st_c      = ST_OK;
    val_c     = '0;
    flag_c    = 1'b0;
    n_next    = n;
    rv_start  = 1'b0;
    if (busy) begin
      // one reverse step: last slot moves to slot rv_i
      ctrl.mode = MD_INS;
      ctrl.idx  = rv_i;
      ctrl.hi   = n - 1'b1;
      ctrl.rd   = n - 1'b1;
      ctrl.data = rd_bus;
    end else if (accept) begin
      case (opcode)
        OP_FRONT, OP_APPEND, OP_INS_AT: begin
          if (n >= CAP) begin
            st_c = ST_FULL;
          end else begin
            ctrl.mode = MD_INS;
            if (opcode == OP_FRONT) begin
              ctrl.idx = '0;
            end else if (opcode == OP_APPEND) begin
              ctrl.idx = n;
            end else if (pos_w <= IDX_W'(1)) begin
              ctrl.idx = '0;
            end else if (pos_w - 1'b1 > n) begin
              ctrl.idx = n;
            end else begin
              ctrl.idx = pos_w - 1'b1;
            end
            n_next = n + 1'b1;
          end
        end
        OP_POP_LST, OP_POP_FST, OP_REM_AT: begin
          if (opcode == OP_POP_LST) begin
            ctrl.idx = n - 1'b1;
          end else if (opcode == OP_POP_FST) begin
            ctrl.idx = '0;
          end else begin
            ctrl.idx = pos_w - 1'b1;
          end
          ctrl.rd = ctrl.idx;
          ctrl.hi = n - 1'b1;
          if (n == '0) begin
            st_c = ST_EMPTY;
          end else if (opcode == OP_REM_AT && (pos_w == '0 || pos_w > n)) begin
            st_c = ST_RANGE;
          end else begin
            ctrl.mode = MD_REM;
            val_c     = rd_bus;
            n_next    = n - 1'b1;
          end
        end
        OP_READ: begin
          if (n == '0) begin
            st_c  = ST_EMPTY;
            val_c = '1;
          end else if (pos_w >= n) begin
            st_c  = ST_RANGE;
            val_c = '1;
          end else begin
            val_c = rd_bus;
          end
        end
        OP_SEARCH: flag_c = any_hit;
        OP_SORTED: flag_c = ~any_bad;
        OP_REVERSE: rv_start = (n >= IDX_W'(2));
        default: begin
        end
      endcase
    end
  end

  assign rv_done = busy && (rv_i == n - IDX_W'(2));

  always_ff @(posedge clk) begin
    if (rst) begin
      n         <= '0;
      busy      <= 1'b0;
      rv_i      <= '0;
      out_valid <= 1'b0;
    end else begin
      n <= n_next;
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (busy) begin
        rv_i <= rv_i + 1'b1;
        if (rv_done) begin
          busy      <= 1'b0;
          out_valid <= 1'b1;
        end
      end else if (accept) begin
        if (rv_start) begin
          busy <= 1'b1;
          rv_i <= '0;
        end else begin
          out_valid <= 1'b1;
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rv_done) begin
      status       <= ST_OK;
      result_value <= '0;
      flag         <= 1'b0;
      count        <= CNT_W'(n);
    end else if (accept && !rv_start) begin
      status       <= st_c;
      result_value <= val_c;
      flag         <= flag_c;
      count        <= CNT_W'(n_next);
    end
  end
endmodule
`default_nettype wire

[tb/tb_indexed_ordered_list_engine.sv]
`default_nettype none
module tb_indexed_ordered_list_engine;
  import iole_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAP = DEF_CAPACITY;
  localparam int CYCLE_LIMIT = 900000;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [OP_W-1:0]   opcode = '0;
  logic [DATA_W-1:0] data_value = '0;
  logic [POS_W-1:0]  position = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [ST_W-1:0]   status;
  logic [DATA_W-1:0] result_value;
  logic              flag;
  logic [CNT_W-1:0]  count;

  indexed_ordered_list_engine #(.CAPACITY(CAP)) i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .opcode(opcode), .data_value(data_value), .position(position),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .result_value(result_value), .flag(flag), .count(count)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // One expected response per command item
  typedef struct {
    logic [ST_W-1:0]   st;
    logic [DATA_W-1:0] val;
    logic              hit;
    logic [CNT_W-1:0]  cnt;
  } list_resp_t;

  list_resp_t        resp_q[$];
  logic [DATA_W-1:0] shadow_list[$];   // mirror of the list contents
  int                errors = 0;
  int                items_sent = 0;
  int                resps_seen = 0;
  int                cycles = 0;
  int                op_hist[16];
  int                full_hits = 0;
  int                rx_wait = 0;      // receiver wait left for the current item
  bit                hold_rx = 1'b0;   // long receiver hold-off
  bit                no_gaps = 1'b0;   // stretches without idling

  // Predictor: applies one command to the mirror and returns its response.
  function automatic list_resp_t apply_cmd(logic [OP_W-1:0] op, logic [DATA_W-1:0] dv,
                                           logic [POS_W-1:0] pos);
    list_resp_t r;
    int n;
    int idx;
    n = shadow_list.size();
    r.st = ST_OK;
    r.val = '0;
    r.hit = 1'b0;
    case (op)
      OP_FRONT, OP_APPEND, OP_INS_AT: begin
        if (n >= CAP) begin
          r.st = ST_FULL;
        end else if (op == OP_FRONT) begin
          shadow_list.push_front(dv);
        end else if (op == OP_APPEND) begin
          shadow_list.push_back(dv);
        end else begin
          // positions 0 and 1 go to the front, past the end appends
          idx = (pos <= 1) ? 0 : int'(pos) - 1;
          if (idx > n) idx = n;
          shadow_list.insert(idx, dv);
        end
      end
      OP_POP_LST: begin
        if (n == 0) r.st = ST_EMPTY;
        else r.val = shadow_list.pop_back();
      end
      OP_POP_FST: begin
        if (n == 0) r.st = ST_EMPTY;
        else r.val = shadow_list.pop_front();
      end
      OP_REM_AT: begin
        if (n == 0) begin
          r.st = ST_EMPTY;
        end else if (pos == 0 || int'(pos) > n) begin
          r.st = ST_RANGE;
        end else begin
          r.val = shadow_list[pos - 1];
          shadow_list.delete(pos - 1);
        end
      end
      OP_READ: begin
        r.val = '1;
        if (n == 0) r.st = ST_EMPTY;
        else if (int'(pos) >= n) r.st = ST_RANGE;
        else r.val = shadow_list[pos];
      end
      OP_SEARCH: begin
        foreach (shadow_list[k]) if (shadow_list[k] == dv) r.hit = 1'b1;
      end
      OP_SORTED: begin
        r.hit = 1'b1;
        for (int k = 0; k + 1 < n; k++)
          if ($signed(shadow_list[k]) > $signed(shadow_list[k + 1])) r.hit = 1'b0;
      end
      OP_REVERSE: begin
        shadow_list.reverse();
      end
      default: ;
    endcase
    r.cnt = CNT_W'(shadow_list.size());
    return r;
  endfunction

  // Sends one item after a random gap; predicts at acceptance.
  task automatic send_item(logic [OP_W-1:0] op, logic [DATA_W-1:0] dv,
                           logic [POS_W-1:0] pos);
    int gap;
    gap = no_gaps ? 0 : (($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 16)) : 0);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    data_value <= dv;
    position <= pos;
    do @(posedge clk); while (in_stall);
    resp_q.push_back(apply_cmd(op, dv, pos));
    if (op <= OP_INS_AT && resp_q[$].st == ST_FULL) full_hits++;
    op_hist[op]++;
    items_sent++;
  endtask

  // Receiver stall: a wait drawn per item, or held for a long stretch on request.
  always @(posedge clk) begin
    if (rst) begin
      rx_wait = 0;
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        rx_wait = no_gaps ? 0 :
                  (($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 16)) : 0);
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      out_stall <= hold_rx || (rx_wait > 0);
    end
  end

  // Response checker
  always @(posedge clk) begin
    list_resp_t e;
    if (!rst && out_valid && !out_stall) begin
      resps_seen++;
      if (resp_q.size() == 0) begin
        $display("%0t: unexpected result st=%0d val=%h flag=%0d cnt=%0d",
                 $time, status, result_value, flag, count);
        errors++;
      end else begin
        e = resp_q.pop_front();
        if (status !== e.st) begin
          $display("%0t: status exp %0d got %0d", $time, e.st, status);
          errors++;
        end
        if (result_value !== e.val) begin
          $display("%0t: value exp %h got %h", $time, e.val, result_value);
          errors++;
        end
        if (flag !== e.hit) begin
          $display("%0t: flag exp %0d got %0d", $time, e.hit, flag);
          errors++;
        end
        if (count !== e.cnt) begin
          $display("%0t: count exp %0d got %0d", $time, e.cnt, count);
          errors++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, resp_q.size());
      $display("tb_indexed_ordered_list_engine failed");
      $finish;
    end
  end

  function automatic logic [DATA_W-1:0] rand_val();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(0, 7);   // small pool so searches hit
      default: return $urandom();
    endcase
  endfunction

  // Empty-list behavior and the field extremes
  task automatic test_directed();
    send_item(OP_POP_LST, '0, 8'd0);
    send_item(OP_POP_FST, '0, 8'd0);
    send_item(OP_REM_AT, '0, 8'd1);
    send_item(OP_READ, '0, 8'd0);
    send_item(OP_SEARCH, 32'h0, 8'd0);
    send_item(OP_SORTED, '0, 8'd0);
    send_item(OP_REVERSE, '0, 8'd0);
    send_item(OP_LENGTH, '0, 8'd0);
    send_item(OP_FRONT, 32'h7fff_ffff, 8'd0);
    send_item(OP_APPEND, 32'h8000_0000, 8'd255);
    send_item(OP_INS_AT, 32'hffff_ffff, 8'd0);
    send_item(OP_INS_AT, 32'h0000_0001, 8'd255);
    send_item(OP_INS_AT, 32'h5555_aaaa, 8'd2);
    send_item(OP_SORTED, '0, 8'd0);
    send_item(OP_SEARCH, 32'h8000_0000, 8'hff);
    send_item(OP_READ, '0, 8'd255);
    send_item(OP_READ, '0, 8'd4);
    send_item(OP_REM_AT, '0, 8'd0);
    send_item(OP_REM_AT, '0, 8'd6);
    send_item(OP_REM_AT, '0, 8'd2);
    send_item(OP_REVERSE, '0, 8'd0);
    send_item(4'd11, 32'hffff_ffff, 8'hff);
    send_item(4'd15, '0, 8'd0);
    send_item(OP_POP_FST, '0, 8'd0);
    send_item(OP_POP_LST, '0, 8'd0);
  endtask

  // Fill to capacity, overflow each insert kind, reverse, drain
  task automatic test_full_list();
    while (shadow_list.size() < CAP)
      send_item(OP_APPEND, DATA_W'(shadow_list.size() * 3), 8'd0);
    send_item(OP_SORTED, '0, 8'd0);
    send_item(OP_FRONT, 32'h1, 8'd0);
    send_item(OP_APPEND, 32'h1, 8'd0);
    send_item(OP_INS_AT, 32'h1, 8'd5);
    send_item(OP_REVERSE, '0, 8'd0);
    send_item(OP_SORTED, '0, 8'd0);
    send_item(OP_READ, '0, POS_W'(CAP - 1));
    send_item(OP_READ, '0, POS_W'(CAP));
    send_item(OP_REM_AT, '0, POS_W'(CAP));
    while (shadow_list.size() > 0)
      send_item($urandom_range(0, 1) ? OP_POP_LST : OP_POP_FST, '0, 8'd0);
  endtask

  // Receiver held off while commands keep coming, so the block backs up; then a gapless random burst
  task automatic test_backpressure();
    hold_rx = 1'b1;
    fork
      begin
        repeat (300) @(posedge clk);
        hold_rx = 1'b0;
      end
      repeat (12) send_item(OP_APPEND, rand_val(), 8'd0);
    join
    no_gaps = 1'b1;
    repeat (60) send_item(OP_W'($urandom_range(0, 10)), rand_val(),
                          POS_W'($urandom_range(0, 20)));
    no_gaps = 1'b0;
  endtask

  // Random mix, biased toward inserts or removals in phases to sweep the length
  task automatic test_random(int n_items);
    logic [OP_W-1:0] op;
    logic [POS_W-1:0] pos;
    int grow;
    for (int i = 0; i < n_items; i++) begin
      if (i % 150 == 0) grow = $urandom_range(0, 2);
      case ($urandom_range(0, 9))
        0, 1, 2: op = OP_W'((grow != 1) ? $urandom_range(0, 2) : $urandom_range(3, 5));
        3, 4:    op = OP_W'((grow == 1) ? $urandom_range(3, 5) : $urandom_range(0, 2));
        5:       op = OP_W'($urandom_range(11, 15));
        default: op = OP_W'($urandom_range(3, 10));
      endcase
      if ($urandom_range(0, 7) == 0) pos = POS_W'($urandom());
      else pos = POS_W'($urandom_range(0, shadow_list.size() + 1));
      send_item(op, rand_val(), pos);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_full_list();
    test_backpressure();
    test_random(1500);
    in_valid <= 1'b0;
    // drain, then allow for a long reverse to settle
    while (resp_q.size() != 0) @(posedge clk);
    repeat (2 * CAP) @(posedge clk);
    $display("%0d commands, %0d results; %0d full-list rejects; ops 0..10: %0d %0d %0d %0d %0d %0d",
             items_sent, resps_seen, full_hits, op_hist[0], op_hist[1], op_hist[2],
             op_hist[3], op_hist[4], op_hist[5]);
    $display("  %0d %0d %0d %0d %0d, unused opcodes and a long receiver hold-off included",
             op_hist[6], op_hist[7], op_hist[8], op_hist[9], op_hist[10]);
    if (errors == 0 && resp_q.size() == 0) begin
      $display("tb_indexed_ordered_list_engine passed");
    end else begin
      $display("tb_indexed_ordered_list_engine failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
